FILE: rtl/core/compass_heading_atan2_top_macros.svh
// Assertion helpers shared by the heading pipeline.
// Each check is clocked on clk_i and is off while rst_ni is low.
`ifndef COMPASS_HEADING_ATAN2_TOP_MACROS_SVH
`define COMPASS_HEADING_ATAN2_TOP_MACROS_SVH

// Same-cycle implication.
`define CAH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CAH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cah_pkg.sv
package cah_pkg;

  // Algorithm settings
  localparam int ITERATIONS = 16;
  localparam int FRAC_BITS  = 6;
  localparam int TABLE_LEN  = 24;
  localparam int GUARD_BITS = 16;
  localparam int ANGLE_FRAC = 24;
  localparam int NSTEPS     = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;

  // Field and datapath widths
  localparam int MAG_W     = 16;
  localparam int HEADING_W = 15;
  localparam int XW        = 36;  // rotated coordinate incl. guard bits and CORDIC gain
  localparam int ZW        = 32;  // accumulated angle, 2^-24 degree units
  localparam int AW        = 35;  // folded angle before rounding
  localparam int RSHIFT    = ANGLE_FRAC - FRAC_BITS;

  // Angle constants in 2^-24 degree units, rounding offset folded in (FULL_TURN is in 2^-6 degree output units)
  localparam logic [AW-1:0] ROUND_HALF = AW'(64'd1 << (RSHIFT - 1));
  localparam logic [AW-1:0] K_BASE_0   = ROUND_HALF;
  localparam logic [AW-1:0] K_BASE_180 = AW'((64'd180 << ANGLE_FRAC) + (64'd1 << (RSHIFT - 1)));
  localparam logic [AW-1:0] K_BASE_360 = AW'((64'd360 << ANGLE_FRAC) + (64'd1 << (RSHIFT - 1)));
  localparam logic [AW-1:0] FULL_TURN  = AW'(64'd360 << FRAC_BITS);

  // Vector state carried down the pipeline
  typedef struct packed {
    logic                 zero;  // input was the zero vector
    logic                 left;  // input was in the left half plane
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cah_vec_t;

  // round(atan(2^-i) * 180/pi * 2^24)
  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ZW-1:0] val;
    case (idx)
      5'd0:    val = 32'sd754974720;
      5'd1:    val = 32'sd445687602;
      5'd2:    val = 32'sd235489088;
      5'd3:    val = 32'sd119537938;
      5'd4:    val = 32'sd60000934;
      5'd5:    val = 32'sd30029717;
      5'd6:    val = 32'sd15018523;
      5'd7:    val = 32'sd7509720;
      5'd8:    val = 32'sd3754917;
      5'd9:    val = 32'sd1877466;
      5'd10:   val = 32'sd938734;
      5'd11:   val = 32'sd469367;
      5'd12:   val = 32'sd234684;
      5'd13:   val = 32'sd117342;
      5'd14:   val = 32'sd58671;
      5'd15:   val = 32'sd29335;
      5'd16:   val = 32'sd14668;
      5'd17:   val = 32'sd7334;
      5'd18:   val = 32'sd3667;
      5'd19:   val = 32'sd1833;
      5'd20:   val = 32'sd917;
      5'd21:   val = 32'sd458;
      5'd22:   val = 32'sd229;
      5'd23:   val = 32'sd115;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/core/cah_prerot.sv
module cah_prerot
  import cah_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic signed [MAG_W-1:0] mag_x_i,
  input  logic signed [MAG_W-1:0] mag_y_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output cah_vec_t                vec_o
);

  logic             valid_q;
  cah_vec_t         vec_q;
  cah_vec_t         vec_d;
  logic [MAG_W:0]   x_ext;
  logic [MAG_W:0]   y_ext;
  logic [MAG_W:0]   x_rot;
  logic [MAG_W:0]   y_rot;
  logic             left;

  // Rotate the left half plane by 180 degrees and scale up by the guard bits
  always_comb begin
    left  = mag_x_i[MAG_W-1];
    x_ext = {mag_x_i[MAG_W-1], mag_x_i};
    y_ext = {mag_y_i[MAG_W-1], mag_y_i};
    x_rot = left ? (~x_ext + 1'b1) : x_ext;
    y_rot = left ? (~y_ext + 1'b1) : y_ext;
    vec_d.zero = (mag_x_i == '0) && (mag_y_i == '0);
    vec_d.left = left;
    vec_d.x    = {{(XW-MAG_W-1-GUARD_BITS){x_rot[MAG_W]}}, x_rot, {GUARD_BITS{1'b0}}};
    vec_d.y    = {{(XW-MAG_W-1-GUARD_BITS){y_rot[MAG_W]}}, y_rot, {GUARD_BITS{1'b0}}};
    vec_d.z    = '0;
  end

  // Hold while full and downstream stalls
  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

FILE: rtl/core/cah_cordic.sv
module cah_cordic
  import cah_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  cah_vec_t vec_i,
  output logic     valid_o,
  input  logic     stall_i,
  output cah_vec_t vec_o
);

  logic     valid_q [NSTEPS];
  cah_vec_t vec_q   [NSTEPS];
  logic     vld_in  [NSTEPS];
  cah_vec_t vec_in  [NSTEPS];
  logic [NSTEPS:0] stall_w;

  assign stall_w[NSTEPS] = stall_i;
  assign stall_o         = stall_w[0];

  // One micro-rotation per register stage
  for (genvar k = 0; k < NSTEPS; k++) begin : g_step
    cah_vec_t             vec_d;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    if (k == 0) begin : g_first
      assign vld_in[k] = valid_i;
      assign vec_in[k] = vec_i;
    end else begin : g_next
      assign vld_in[k] = valid_q[k-1];
      assign vec_in[k] = vec_q[k-1];
    end

    // Stage holds while full and the next one stalls
    assign stall_w[k] = valid_q[k] && stall_w[k+1];

    always_comb begin
      dx    = vec_in[k].y >>> k;
      dy    = vec_in[k].x >>> k;
      vec_d = vec_in[k];
      if (!vec_in[k].y[XW-1]) begin
        vec_d.x = vec_in[k].x + dx;
        vec_d.y = vec_in[k].y - dy;
        vec_d.z = vec_in[k].z + atan_entry(5'(k));
      end else begin
        vec_d.x = vec_in[k].x - dx;
        vec_d.y = vec_in[k].y + dy;
        vec_d.z = vec_in[k].z - atan_entry(5'(k));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (!stall_w[k]) begin
        valid_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!stall_w[k] && vld_in[k]) begin
        vec_q[k] <= vec_d;
      end
    end
  end

  assign valid_o = valid_q[NSTEPS-1];
  assign vec_o   = vec_q[NSTEPS-1];

endmodule

FILE: rtl/core/cah_post.sv
`include "compass_heading_atan2_top_macros.svh"

module cah_post
  import cah_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  cah_vec_t             vec_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic [HEADING_W-1:0] heading_o
);

  logic                 valid_q;
  logic [HEADING_W-1:0] heading_q;
  logic [HEADING_W-1:0] heading_d;
  logic [AW-1:0]        z_ext;
  logic [AW-1:0]        offset;
  logic [AW-1:0]        sum;
  logic [AW-1:0]        rounded;

  // Add base angle, fold negatives into [0,360), round half up, wrap 360 to 0, zero vector to 0
  always_comb begin
    z_ext = {{(AW-ZW){vec_i.z[ZW-1]}}, vec_i.z};
    if (vec_i.left) begin
      offset = K_BASE_180;
    end else if (vec_i.z[ZW-1]) begin
      offset = K_BASE_360;
    end else begin
      offset = K_BASE_0;
    end
    sum     = z_ext + offset;
    rounded = sum >> RSHIFT;
    if (vec_i.zero || (rounded == FULL_TURN)) begin
      heading_d = '0;
    end else begin
      heading_d = rounded[HEADING_W-1:0];
    end
  end

  // Output register: hold while the consumer stalls
  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      heading_q <= heading_d;
    end
  end

  assign valid_o   = valid_q;
  assign heading_o = heading_q;

  `CAH_ASSERT_NOW(a_heading_range, valid_q, AW'(heading_q) < FULL_TURN, "heading out of range")
  `CAH_ASSERT_NEXT(a_zero_vector, valid_i && !stall_o && vec_i.zero, heading_q == '0, "zero vector gave nonzero heading")
  `CAH_ASSERT_NEXT(a_left_plane, valid_i && !stall_o && vec_i.left && !vec_i.zero, heading_q != '0, "left half plane gave zero heading")

endmodule

FILE: rtl/core/compass_heading_atan2_top.sv
// Compass heading from one signed 16-bit magnetometer X,Y pair per transfer:
// heading_o = atan2(mag_y_i, mag_x_i) in degrees, folded into [0,360), as
// unsigned fixed point with cah_pkg::FRAC_BITS fractional bits (degrees * 64,
// 0..23039 by default); a result that rounds to 360 reads 0, and (0,0) gives 0.
// The block keeps no state. It takes one pair every cycle while in_stall_o is
// low; each result passes through these register stages in turn: one stage
// for the half-plane rotation, one per vectoring-mode CORDIC micro-rotation,
// and one for the fold, rounding and output register. Every stage holds its
// data while full and stalled, so bubbles close up and out_stall_i reaches
// in_stall_o only when the whole pipeline is full.
`include "compass_heading_atan2_top_macros.svh"

module compass_heading_atan2_top
  import cah_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [MAG_W-1:0] mag_x_i,
  input  logic signed [MAG_W-1:0] mag_y_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [HEADING_W-1:0]    heading_o
);

  logic     pre_valid;
  logic     pre_stall;
  cah_vec_t pre_vec;
  logic     cor_valid;
  logic     cor_stall;
  cah_vec_t cor_vec;

  // Fold the input into the right half plane
  cah_prerot u_prerot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .mag_x_i (mag_x_i),
    .mag_y_i (mag_y_i),
    .valid_o (pre_valid),
    .stall_i (pre_stall),
    .vec_o   (pre_vec)
  );

  // Drive y to zero while accumulating the angle
  cah_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pre_valid),
    .stall_o (pre_stall),
    .vec_i   (pre_vec),
    .valid_o (cor_valid),
    .stall_i (cor_stall),
    .vec_o   (cor_vec)
  );

  // Convert the angle to the output heading
  cah_post u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (cor_valid),
    .stall_o   (cor_stall),
    .vec_i     (cor_vec),
    .valid_o   (out_valid_o),
    .stall_i   (out_stall_i),
    .heading_o (heading_o)
  );

  `CAH_ASSERT_NOW(a_stall_needs_full, in_stall_o, out_valid_o && out_stall_i, "input stalled with output free")

endmodule

FILE: dv/compass_heading_atan2_checker.sv
`timescale 1ns / 100ps

module compass_heading_atan2_checker
  import cah_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [MAG_W-1:0] mag_x_i,
  input  logic signed [MAG_W-1:0] mag_y_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [HEADING_W-1:0]    heading_i,
  output int                      mismatch_count_o,
  output int                      pending_o
);

  // One expected heading, with the pair that produced it for reporting
  typedef struct {
    logic signed [MAG_W-1:0] mx;
    logic signed [MAG_W-1:0] my;
    logic [HEADING_W-1:0]    heading;
  } heading_exp_t;

  heading_exp_t expected_headings[$];

  // atan(2^-i) in degrees, scaled by 2^24
  longint atan_deg_q24 [24] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934,  30029717,  15018523,  7509720,
    3754917,   1877466,   938734,    469367,
    234684,    117342,    58671,     29335,
    14668,     7334,      3667,      1833,
    917,       458,       229,       115
  };

  // Vectoring-mode CORDIC heading in degrees * 2^FRAC_BITS, folded into [0,360)
  function automatic logic [HEADING_W-1:0] heading_deg_fx(
    input logic signed [MAG_W-1:0] mx,
    input logic signed [MAG_W-1:0] my
  );
    longint xs, ys, x, y, z, dx, dy, base, angle, rounded;
    longint full_turn_q24, wrap_limit;
    int     drop_bits;
    xs            = longint'(mx);
    ys            = longint'(my);
    full_turn_q24 = longint'(360) <<< ANGLE_FRAC;
    wrap_limit    = longint'(360) <<< FRAC_BITS;
    drop_bits     = ANGLE_FRAC - FRAC_BITS;
    if (xs == 0 && ys == 0) begin
      return '0;
    end
    // Rotate the left half plane by 180 degrees
    base = 0;
    if (xs < 0) begin
      xs   = -xs;
      ys   = -ys;
      base = longint'(180) <<< ANGLE_FRAC;
    end
    x = xs <<< GUARD_BITS;
    y = ys <<< GUARD_BITS;
    z = 0;
    // Drive y toward zero, accumulating the angle
    for (int i = 0; i < NSTEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_deg_q24[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_deg_q24[i];
      end
    end
    // Fold, round half up, wrap a full turn to zero
    angle = base + z;
    if (angle < 0) begin
      angle = angle + full_turn_q24;
    end
    if (angle < 0) begin
      angle = 0;
    end
    if (drop_bits == 0) begin
      rounded = angle;
    end else begin
      rounded = (angle + (longint'(1) <<< (drop_bits - 1))) >>> drop_bits;
    end
    if (rounded >= wrap_limit) begin
      rounded = rounded - wrap_limit;
    end
    return rounded[HEADING_W-1:0];
  endfunction

  // Predict on each input transfer, compare on each output transfer
  always @(posedge clk_i) begin
    heading_exp_t exp_item;
    heading_exp_t got_item;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        exp_item.mx      = mag_x_i;
        exp_item.my      = mag_y_i;
        exp_item.heading = heading_deg_fx(mag_x_i, mag_y_i);
        expected_headings.push_back(exp_item);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_headings.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("%0t: unexpected heading transfer, heading=%0d", $realtime, heading_i);
          end
          mismatch_count_o++;
        end else begin
          got_item = expected_headings.pop_front();
          if (heading_i !== got_item.heading) begin
            if (mismatch_count_o < 10) begin
              $display("%0t: heading mismatch for x=%0d y=%0d: expected %0d, got %0d",
                       $realtime, got_item.mx, got_item.my, got_item.heading, heading_i);
            end
            mismatch_count_o++;
          end
        end
      end
      pending_o = expected_headings.size();
    end else begin
      mismatch_count_o = 0;
      pending_o        = 0;
    end
  end

endmodule

FILE: dv/compass_heading_atan2_top_tb.sv
`timescale 1ns / 100ps

module compass_heading_atan2_top_tb;
  import cah_pkg::*;

  localparam int NUM_RANDOM_PAIRS = 1500;
  localparam int IDLE_LIMIT       = 1000;
  localparam int DRAIN_CYCLES     = 40;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic signed [MAG_W-1:0] mag_x_i     = '0;
  logic signed [MAG_W-1:0] mag_y_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [HEADING_W-1:0]    heading_o;

  int mismatch_count;
  int pending_headings;
  int idle_cycles = 0;

  compass_heading_atan2_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mag_x_i     (mag_x_i),
    .mag_y_i     (mag_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .heading_o   (heading_o)
  );

  compass_heading_atan2_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .mag_x_i          (mag_x_i),
    .mag_y_i          (mag_y_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .heading_i        (heading_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_headings)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver stall: switch between several patterns, each held for a random span
  int stall_mode      = 0;
  int stall_mode_left = 0;
  int stall_period_on = 1;
  int stall_phase     = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode      = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(20, 300);
        stall_period_on = $urandom_range(1, 7);
      end
      stall_mode_left--;
      stall_phase = (stall_phase + 1) % 8;
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (stall_phase < stall_period_on);
      endcase
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[compass_heading_atan2_top] ERROR");
        $finish;
      end
    end
  end

  // Present one pair and hold it until it transfers; returns at a falling edge
  task automatic send_pair(input logic signed [MAG_W-1:0] x, input logic signed [MAG_W-1:0] y);
    in_valid_i <= 1'b1;
    mag_x_i    <= x;
    mag_y_i    <= y;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Drop valid for a number of cycles
  task automatic hold_off(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Drop valid until every expected heading has come back
  task automatic drain_headings();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_headings != 0) @(negedge clk_i);
  endtask

  // Random axis value: full range, near zero, or near full scale
  function automatic logic signed [MAG_W-1:0] draw_axis();
    logic signed [MAG_W-1:0] val;
    case ($urandom_range(0, 3))
      0:       val = MAG_W'($urandom_range(0, 32) - 16);
      1:       val = ($urandom_range(0, 1) != 0) ? MAG_W'(32767 - $urandom_range(0, 15))
                                                 : MAG_W'(-32768 + $urandom_range(0, 15));
      default: val = MAG_W'($urandom);
    endcase
    return val;
  endfunction

  initial begin
    int sent;
    int burst_len;
    bit drained_mid;
    sent        = 0;
    drained_mid = 1'b0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero vector, axes, extremes, diagonals, wrap to zero near 360
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd32767, 16'sd0);
    send_pair(-16'sd32768, 16'sd0);
    send_pair(16'sd0, 16'sd32767);
    send_pair(16'sd0, -16'sd32768);
    send_pair(16'sd32767, 16'sd32767);
    send_pair(-16'sd32768, -16'sd32768);
    send_pair(-16'sd32768, 16'sd32767);
    send_pair(16'sd32767, -16'sd32768);
    send_pair(16'sd1, 16'sd0);
    send_pair(-16'sd1, 16'sd0);
    send_pair(16'sd0, 16'sd1);
    send_pair(16'sd0, -16'sd1);
    send_pair(16'sd1, 16'sd1);
    send_pair(-16'sd1, -16'sd1);
    send_pair(16'sd1, -16'sd1);
    send_pair(-16'sd1, 16'sd1);
    send_pair(16'sd32767, -16'sd1);
    send_pair(16'sd32767, 16'sd1);
    send_pair(-16'sd32768, -16'sd1);
    send_pair(-16'sd32768, 16'sd1);
    send_pair(16'sh5555, -16'sh5556);
    send_pair(-16'sh5556, 16'sh5555);
    drain_headings();

    // Random bursts with random gaps, some back to back
    while (sent < NUM_RANDOM_PAIRS) begin
      burst_len = $urandom_range(1, 48);
      for (int i = 0; i < burst_len; i++) begin
        send_pair(draw_axis(), draw_axis());
        sent++;
      end
      if ((!drained_mid && sent >= NUM_RANDOM_PAIRS / 2) || $urandom_range(0, 24) == 0) begin
        drained_mid = 1'b1;
        drain_headings();
      end else if ($urandom_range(0, 3) != 0) begin
        hold_off($urandom_range(1, 10));
      end
    end

    // Let the pipeline empty, then give the verdict
    drain_headings();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && pending_headings == 0) begin
      $display("[compass_heading_atan2_top] OK");
    end else begin
      $display("[compass_heading_atan2_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: compass_heading_atan2_top.f
+incdir+rtl/core
rtl/core/cah_pkg.sv
rtl/core/cah_prerot.sv
rtl/core/cah_cordic.sv
rtl/core/cah_post.sv
rtl/core/compass_heading_atan2_top.sv
dv/compass_heading_atan2_checker.sv
dv/compass_heading_atan2_top_tb.sv
